[rtl/adv_data_name_extractor_unit_macros.svh]
// Assertion macros used by the checker file of the name extractor
`ifndef ADV_DATA_NAME_EXTRACTOR_UNIT_MACROS_SVH
`define ADV_DATA_NAME_EXTRACTOR_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define ADNE_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("adne: same-cycle check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define ADNE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("adne: next-cycle check failed");

`endif

[rtl/adne_pkg.sv]
// Package with types and constants of the advertising-data name extractor
`default_nettype none

package adne_pkg;

    typedef enum logic [1:0] {
        ST_BYTE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_NONE  = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_SCAN = 4'b0010,
        PH_TYPE = 4'b0100,
        PH_NAME = 4'b1000
    } phase_t;

    localparam logic [7:0] AD_TYPE_SHORT_NAME    = 8'h08;
    localparam logic [7:0] AD_TYPE_COMPLETE_NAME = 8'h09;

    localparam int         APB_AW         = 3;
    localparam int         APB_DW         = 32;
    localparam int         NAME_MAX_W     = 5;
    localparam logic [NAME_MAX_W-1:0] NAME_MAX_RESET = 5'd29;

    // word index of the registers (paddr[2])
    localparam logic       REG_NAME_MAX   = 1'b0;

endpackage

`default_nettype wire

[rtl/adne_if.sv]
// Valid/ready channel interfaces for report bytes and name results
`default_nettype none

interface adne_report_if;
    logic       valid;
    logic       ready;
    logic [7:0] report_byte;
    logic       first_byte;
    logic [4:0] report_len;

    modport source (output valid, output report_byte, output first_byte,
                    output report_len, input ready);
    modport sink   (input valid, input report_byte, input first_byte,
                    input report_len, output ready);
endinterface

interface adne_name_if;
    logic              valid;
    logic              ready;
    logic [7:0]        name_byte;
    adne_pkg::status_t status;
    logic              last_of_run;

    modport source (output valid, output name_byte, output status,
                    output last_of_run, input ready);
    modport sink   (input valid, input name_byte, input status,
                    input last_of_run, output ready);
endinterface

`default_nettype wire

[rtl/adv_data_name_extractor_unit.sv]
// Top level: walks advertising/EIR reports and emits the local name bytes
`default_nettype none

// Takes one report byte per cycle and gives at most one result per byte,
// in the cycle after the byte is taken. The parser state (phase, offset,
// bytes left in the current structure) is updated in the same cycle a
// byte is accepted; the result goes to a single output register. report_in
// is ready whenever that register is empty or is being drained, so the
// sustained rate is one byte per cycle as long as name_out takes its beats.
// Each report yields either its name bytes (last one flagged), one
// empty-name beat, or one not-found beat; further bytes are dropped until
// the next first_byte. name_max is written over APB at address 0.
module adv_data_name_extractor_unit #(
    parameter int MAX_REPORT_BYTES = 31
) (
    input  wire                             clk,
    input  wire                             rst_n,
    adne_report_if.sink                     report_in,
    adne_name_if.source                     name_out,
    input  wire                             psel,
    input  wire                             penable,
    input  wire                             pwrite,
    input  wire  [adne_pkg::APB_AW-1:0]     paddr,
    input  wire  [adne_pkg::APB_DW-1:0]     pwdata,
    output logic [adne_pkg::APB_DW-1:0]     prdata,
    output logic                            pready
);
    import adne_pkg::*;

    localparam int OW = (MAX_REPORT_BYTES < 2) ? 1 : $clog2(MAX_REPORT_BYTES + 1);
    localparam int SW = ((OW > 8) ? OW : 8) + 2;
    localparam logic [OW-1:0] MAX_OFF = OW'(MAX_REPORT_BYTES);

    logic [NAME_MAX_W-1:0] name_max_reg;

    phase_t      phase_reg, phase_next, cur_phase;
    logic [OW-1:0] offset_reg, offset_next, cur_off;
    logic [7:0]  remain_reg, remain_next, cur_rem;
    logic [7:0]  flen_reg, flen_next, cur_len;

    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    status_t     out_status_reg;
    logic        out_last_reg;

    logic        res_valid;
    logic [7:0]  res_byte;
    status_t     res_status;
    logic        res_last;

    logic        take;
    logic        cfg_wr;
    logic [SW-1:0] eff, off_w;
    logic        at_end, overrun, is_name;
    logic [7:0]  b, data_len, rem_dec;

    // APB
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_NAME_MAX);

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_NAME_MAX)
        begin
            prdata = APB_DW'(name_max_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            name_max_reg <= NAME_MAX_RESET;
        end
        else if (cfg_wr)
        begin
            name_max_reg <= pwdata[NAME_MAX_W-1:0];
        end
    end

    // handshake
    assign report_in.ready = !out_valid_reg || name_out.ready;
    assign take            = report_in.valid && report_in.ready;

    // parse step
    always_comb
    begin
        b         = report_in.report_byte;
        cur_phase = report_in.first_byte ? PH_SCAN : phase_reg;
        cur_off   = report_in.first_byte ? '0 : offset_reg;
        cur_rem   = report_in.first_byte ? '0 : remain_reg;
        cur_len   = report_in.first_byte ? '0 : flen_reg;

        eff     = (SW'(report_in.report_len) > SW'(MAX_REPORT_BYTES))
                  ? SW'(MAX_REPORT_BYTES) : SW'(report_in.report_len);
        off_w   = SW'(cur_off);
        at_end  = (off_w + SW'(1)) >= eff;
        overrun = (off_w + SW'(b) + SW'(1)) > eff;
        is_name = (b == AD_TYPE_SHORT_NAME) || (b == AD_TYPE_COMPLETE_NAME);
        data_len = (cur_len != 8'd0) ? (cur_len - 8'd1) : 8'd0;
        rem_dec  = (cur_rem != 8'd0) ? (cur_rem - 8'd1) : 8'd0;

        phase_next  = cur_phase;
        offset_next = (cur_off < MAX_OFF) ? (cur_off + OW'(1)) : MAX_OFF;
        remain_next = cur_rem;
        flen_next   = cur_len;

        res_valid  = 1'b0;
        res_byte   = 8'd0;
        res_status = ST_NONE;
        res_last   = 1'b1;

        case (cur_phase)
            PH_SCAN:
            begin
                if (cur_rem != 8'd0)
                begin
                    remain_next = rem_dec;
                    if (at_end)
                    begin
                        res_valid  = 1'b1;
                        phase_next = PH_IDLE;
                    end
                end
                else if ((b == 8'd0) || overrun)
                begin
                    res_valid  = 1'b1;
                    phase_next = PH_IDLE;
                end
                else
                begin
                    flen_next  = b;
                    phase_next = PH_TYPE;
                end
            end
            PH_TYPE:
            begin
                remain_next = data_len;
                if (is_name)
                begin
                    if (data_len > 8'(name_max_reg))
                    begin
                        res_valid  = 1'b1;
                        phase_next = PH_IDLE;
                    end
                    else if (data_len == 8'd0)
                    begin
                        res_valid  = 1'b1;
                        res_status = ST_EMPTY;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        phase_next = PH_NAME;
                    end
                end
                else
                begin
                    phase_next = PH_SCAN;
                    if (at_end)
                    begin
                        res_valid  = 1'b1;
                        phase_next = PH_IDLE;
                    end
                end
            end
            PH_NAME:
            begin
                remain_next = rem_dec;
                res_valid   = 1'b1;
                res_byte    = b;
                res_status  = ST_BYTE;
                res_last    = (rem_dec == 8'd0);
                if (rem_dec == 8'd0)
                begin
                    phase_next = PH_IDLE;
                end
            end
            default:
            begin
                // idle: byte dropped, state kept
                offset_next = cur_off;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            offset_reg <= '0;
            remain_reg <= '0;
            flen_reg   <= '0;
        end
        else if (take)
        begin
            phase_reg  <= phase_next;
            offset_reg <= offset_next;
            remain_reg <= remain_next;
            flen_reg   <= flen_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            out_valid_reg <= res_valid;
        end
        else if (name_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && res_valid)
        begin
            out_byte_reg   <= res_byte;
            out_status_reg <= res_status;
            out_last_reg   <= res_last;
        end
    end

    assign name_out.valid       = out_valid_reg;
    assign name_out.name_byte   = out_byte_reg;
    assign name_out.status      = out_status_reg;
    assign name_out.last_of_run = out_last_reg;

endmodule

`default_nettype wire

[rtl/adne_checker.sv]
// Port-level checker for the name extractor, bound to the top level
`default_nettype none

`include "adv_data_name_extractor_unit_macros.svh"

module adne_checker (
    input wire       clk,
    input wire       rst_n,
    input wire       in_valid,
    input wire       in_ready,
    input wire       out_valid,
    input wire       out_ready,
    input wire [7:0] out_byte,
    input wire [1:0] out_status,
    input wire       out_last
);
    import adne_pkg::*;

    // a stalled beat stays put
    `ADNE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(out_status) && $stable(out_last))

    // status beats close the run and carry no byte
    `ADNE_ASSERT_SAME(a_status_last, out_valid && (out_status != ST_BYTE), out_last && (out_byte == 8'd0))

    // an empty result register never blocks input
    `ADNE_ASSERT_SAME(a_ready_when_empty, !out_valid, in_ready)

    // a fresh beat comes only from a byte taken the cycle before
    `ADNE_ASSERT_NEXT(a_no_invent, !(in_valid && in_ready) && !(out_valid && !out_ready), !out_valid)

endmodule

bind adv_data_name_extractor_unit adne_checker u_adne_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (report_in.valid),
    .in_ready   (report_in.ready),
    .out_valid  (name_out.valid),
    .out_ready  (name_out.ready),
    .out_byte   (name_out.name_byte),
    .out_status (name_out.status),
    .out_last   (name_out.last_of_run)
);

`default_nettype wire
